[rtl/touch_clamp_polar_convert_defines.svh]
// Assertion macros for the touch clamp and polar conversion block.
// Taken in by the top level; needs a clock named clk and a reset named rst in scope.
`ifndef TOUCH_CLAMP_POLAR_CONVERT_DEFINES_SVH
`define TOUCH_CLAMP_POLAR_CONVERT_DEFINES_SVH

// Implication checked at every rising edge of clk, ignored while rst is high.
`define TCPC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define TCPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/tcpc_pkg.sv]
// Shared types, constants and the arctangent table of the touch clamp and polar block.
// Used by every module in rtl; depends on nothing else.
package tcpc_pkg;

  localparam int XY_W   = 11;
  localparam int Z_W    = 6;
  localparam int BTN_W  = 3;
  localparam int ANG_W  = 16;
  localparam int RAD_W  = 15;
  localparam int IDX_W  = 3;

  localparam int IN_W   = 32;
  localparam int OUT_W  = 64;

  // CORDIC pipeline depth; the table below covers at most ATAN_LEN stages.
  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_LEN      = 24;
  localparam int STAGE_W       = $clog2(ATAN_LEN);

  // Vector components carry the offset scaled by 256 plus the CORDIC growth.
  localparam int CV_W   = 23;
  localparam int ACC_W  = 26;
  localparam int PROD_W = CV_W - 1 + 16;

  localparam int HALF_TURN = 23040;
  localparam int GAIN_Q16  = 39797;

  localparam logic signed [ACC_W-1:0] ACC_HALF_TURN = ACC_W'(HALF_TURN * 256);
  localparam logic signed [ACC_W-1:0] ANG_MAX       = ACC_W'(HALF_TURN);
  localparam logic signed [ACC_W-1:0] ANG_MIN       = -ACC_W'(HALF_TURN - 1);
  localparam logic [PROD_W:0]         RAD_ROUND     = (PROD_W+1)'(1 << 19);
  localparam logic [PROD_W-20:0]      RAD_MAX       = (PROD_W-19)'(32767);

  // Register indexes on the configuration port.
  localparam logic [IDX_W-1:0] REG_X_LOW  = 3'd0;
  localparam logic [IDX_W-1:0] REG_X_HIGH = 3'd1;
  localparam logic [IDX_W-1:0] REG_Y_LOW  = 3'd2;
  localparam logic [IDX_W-1:0] REG_Y_HIGH = 3'd3;
  localparam logic [IDX_W-1:0] REG_X_CTR  = 3'd4;
  localparam logic [IDX_W-1:0] REG_Y_CTR  = 3'd5;

  typedef struct packed {
    logic [XY_W-1:0] x_low_limit;
    logic [XY_W-1:0] x_high_limit;
    logic [XY_W-1:0] y_low_limit;
    logic [XY_W-1:0] y_high_limit;
    logic [XY_W-1:0] x_center;
    logic [XY_W-1:0] y_center;
  } cfg_t;

  // One report in flight through the pipeline.
  typedef struct packed {
    logic [XY_W-1:0]         x_clamped;
    logic [XY_W-1:0]         y_clamped;
    logic [Z_W-1:0]          z_out;
    logic [BTN_W-1:0]        buttons_out;
    logic                    idle_flag;
    logic                    zero_vec;
    logic signed [CV_W-1:0]  cx;
    logic signed [CV_W-1:0]  cy;
    logic signed [ACC_W-1:0] acc;
  } item_t;

  // atan(2^-i) in units of 1/32768 degree, rounded to nearest.
  function automatic logic signed [ACC_W-1:0] atan_entry(input logic [STAGE_W-1:0] idx);
    logic signed [ACC_W-1:0] val;
    case (idx)
      5'd0:    val = ACC_W'(1474560);
      5'd1:    val = ACC_W'(870484);
      5'd2:    val = ACC_W'(459940);
      5'd3:    val = ACC_W'(233473);
      5'd4:    val = ACC_W'(117189);
      5'd5:    val = ACC_W'(58652);
      5'd6:    val = ACC_W'(29333);
      5'd7:    val = ACC_W'(14667);
      5'd8:    val = ACC_W'(7334);
      5'd9:    val = ACC_W'(3667);
      5'd10:   val = ACC_W'(1833);
      5'd11:   val = ACC_W'(917);
      5'd12:   val = ACC_W'(458);
      5'd13:   val = ACC_W'(229);
      5'd14:   val = ACC_W'(115);
      5'd15:   val = ACC_W'(57);
      5'd16:   val = ACC_W'(29);
      5'd17:   val = ACC_W'(14);
      5'd18:   val = ACC_W'(7);
      5'd19:   val = ACC_W'(4);
      5'd20:   val = ACC_W'(2);
      5'd21:   val = ACC_W'(1);
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

[rtl/tcpc_front.sv]
// Input stage: clamps the report, subtracts the center and pre-rotates into the right half plane.
// Depends on tcpc_pkg.
module tcpc_front
  import tcpc_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  cfg_t            cfg,
  input  logic            in_valid,
  input  logic [IN_W-1:0] in_data,
  output logic            out_valid,
  output item_t           out_item
);

  logic [XY_W-1:0]        x_in;
  logic [XY_W-1:0]        y_in;
  logic [Z_W-1:0]         z_in;
  logic [BTN_W-1:0]       b_in;
  logic                   touch;
  logic [XY_W-1:0]        x_cl;
  logic [XY_W-1:0]        y_cl;
  logic signed [XY_W:0]   dx;
  logic signed [XY_W:0]   dy;
  logic signed [CV_W-1:0] cx0;
  logic signed [CV_W-1:0] cy0;
  item_t                  item_next;

  assign x_in  = in_data[XY_W-1:0];
  assign y_in  = in_data[2*XY_W-1:XY_W];
  assign z_in  = in_data[2*XY_W+Z_W-1:2*XY_W];
  assign b_in  = in_data[2*XY_W+Z_W+BTN_W-1:2*XY_W+Z_W];
  assign touch = (z_in != '0);

  // The high limit is tested first; with crossed limits it wins for inputs above it.
  always_comb begin
    x_cl = x_in;
    y_cl = y_in;
    if (touch) begin
      if (x_in > cfg.x_high_limit) x_cl = cfg.x_high_limit;
      else if (x_in < cfg.x_low_limit) x_cl = cfg.x_low_limit;
      if (y_in > cfg.y_high_limit) y_cl = cfg.y_high_limit;
      else if (y_in < cfg.y_low_limit) y_cl = cfg.y_low_limit;
    end
  end

  assign dx  = $signed({1'b0, x_cl}) - $signed({1'b0, cfg.x_center});
  assign dy  = $signed({1'b0, y_cl}) - $signed({1'b0, cfg.y_center});
  assign cx0 = $signed({{(CV_W-XY_W-9){dx[XY_W]}}, dx, 8'd0});
  assign cy0 = $signed({{(CV_W-XY_W-9){dy[XY_W]}}, dy, 8'd0});

  always_comb begin
    item_next.x_clamped   = x_cl;
    item_next.y_clamped   = y_cl;
    item_next.z_out       = z_in;
    item_next.buttons_out = b_in;
    item_next.idle_flag   = !touch;
    item_next.zero_vec    = (dx == '0) && (dy == '0);
    if (dx < 0) begin
      item_next.cx  = -cx0;
      item_next.cy  = -cy0;
      item_next.acc = (dy >= 0) ? ACC_HALF_TURN : -ACC_HALF_TURN;
    end else begin
      item_next.cx  = cx0;
      item_next.cy  = cy0;
      item_next.acc = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= item_next;
    end
  end

endmodule

[rtl/tcpc_cell.sv]
// One vectoring CORDIC micro-rotation with its pipeline register.
// Depends on tcpc_pkg for the item type and the arctangent table.
module tcpc_cell
  import tcpc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic [STAGE_W-1:0] stage_idx,
  input  logic               in_valid,
  input  item_t              in_item,
  output logic               out_valid,
  output item_t              out_item
);

  logic signed [CV_W-1:0]  sx;
  logic signed [CV_W-1:0]  sy;
  logic signed [ACC_W-1:0] ang;
  item_t                   item_next;

  // Arithmetic shifts round toward minus infinity, as the rotation expects.
  assign sx  = in_item.cx >>> stage_idx;
  assign sy  = in_item.cy >>> stage_idx;
  assign ang = atan_entry(stage_idx);

  always_comb begin
    item_next = in_item;
    if (in_item.cy >= 0) begin
      item_next.cx  = in_item.cx + sy;
      item_next.cy  = in_item.cy - sx;
      item_next.acc = in_item.acc + ang;
    end else begin
      item_next.cx  = in_item.cx - sy;
      item_next.cy  = in_item.cy + sx;
      item_next.acc = in_item.acc - ang;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= item_next;
    end
  end

endmodule

[rtl/tcpc_back.sv]
// Output stage: rounds and limits the angle, compensates the radius for the CORDIC gain,
// and holds the result register of the master side. Depends on tcpc_pkg.
module tcpc_back
  import tcpc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  item_t            in_item,
  output logic             out_valid,
  output logic [OUT_W-1:0] out_data
);

  logic signed [ACC_W-1:0] acc_rnd;
  logic signed [ACC_W-1:0] ang_full;
  logic signed [ACC_W-1:0] ang_lim;
  logic [CV_W-2:0]         x_pos;
  logic [PROD_W-1:0]       prod;
  logic [PROD_W:0]         prod_rnd;
  logic [PROD_W-20:0]      rad_full;
  logic [ANG_W-1:0]        angle;
  logic [RAD_W-1:0]        radius;
  logic                    no_polar;

  assign acc_rnd  = in_item.acc + ACC_W'(128);
  assign ang_full = acc_rnd >>> 8;

  always_comb begin
    if (ang_full > ANG_MAX) ang_lim = ANG_MAX;
    else if (ang_full < ANG_MIN) ang_lim = ANG_MIN;
    else ang_lim = ang_full;
  end

  assign x_pos    = (in_item.cx < 0) ? '0 : in_item.cx[CV_W-2:0];
  assign prod     = PROD_W'(x_pos) * PROD_W'(GAIN_Q16);
  assign prod_rnd = {1'b0, prod} + RAD_ROUND;
  assign rad_full = prod_rnd[PROD_W:20];

  assign no_polar = in_item.idle_flag || in_item.zero_vec;
  assign angle    = no_polar ? '0 : ang_lim[ANG_W-1:0];
  assign radius   = no_polar ? '0 :
                    (rad_full > RAD_MAX) ? RAD_W'(32767) : rad_full[RAD_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= {1'b0, radius, angle, in_item.idle_flag, in_item.buttons_out,
                   in_item.z_out, in_item.y_clamped, in_item.x_clamped};
    end
  end

endmodule

[rtl/touch_clamp_polar_convert.sv]
// Touch report clamp and cartesian-to-polar conversion, top level.
// Depends on tcpc_pkg, tcpc_front, tcpc_cell, tcpc_back and the assertion macro header.
//
// Usage:
//   A report enters on the slave stream (s_tvalid, s_tready, s_tdata) and its
//   result leaves on the master stream (m_tvalid, m_tready, m_tdata), one result
//   per report and in order. The six clamp and center registers are written through
//   cfg_we, cfg_index and cfg_data; the user must write them only while no report
//   is in flight, as the block itself does not enforce this. The pipeline is one
//   input stage, one cell per micro-rotation, and the output register. Throughput
//   is one report per cycle while the receiver does not hold a result, and each
//   rotation cell is a register deep. Reset clears every valid bit and loads the
//   register defaults; the pipeline is empty and ready as soon as reset is released.
//   While the receiver holds a result (m_tvalid high, m_tready low) the whole
//   chain freezes and s_tready drops; nothing is lost or repeated.
`include "touch_clamp_polar_convert_defines.svh"

module touch_clamp_polar_convert
  import tcpc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // x_position[10:0], y_position[21:11], z_level[27:22], button_bits[30:28]
  input  logic [IN_W-1:0]  s_tdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  // x_clamped[10:0], y_clamped[21:11], z_out[27:22], buttons_out[30:28],
  // idle_flag[31], angle_deg[47:32], radius_fixed[62:48]
  output logic [OUT_W-1:0] m_tdata,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [XY_W-1:0]  cfg_data
);

  cfg_t  cfg;
  logic  en;
  logic  front_valid;
  item_t front_item;
  logic  chain_valid [0:CORDIC_STAGES];
  item_t chain_item  [0:CORDIC_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.x_low_limit  <= XY_W'(128);
      cfg.x_high_limit <= XY_W'(1920);
      cfg.y_low_limit  <= XY_W'(64);
      cfg.y_high_limit <= XY_W'(1472);
      cfg.x_center     <= XY_W'(960);
      cfg.y_center     <= XY_W'(736);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_X_LOW:  cfg.x_low_limit  <= cfg_data;
        REG_X_HIGH: cfg.x_high_limit <= cfg_data;
        REG_Y_LOW:  cfg.y_low_limit  <= cfg_data;
        REG_Y_HIGH: cfg.y_high_limit <= cfg_data;
        REG_X_CTR:  cfg.x_center     <= cfg_data;
        REG_Y_CTR:  cfg.y_center     <= cfg_data;
        default: ;
      endcase
    end
  end

  // The chain advances whenever the output register is free or being emptied.
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  tcpc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_data   (s_tdata),
    .out_valid (front_valid),
    .out_item  (front_item)
  );

  assign chain_valid[0] = front_valid;
  assign chain_item[0]  = front_item;

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    tcpc_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .stage_idx (STAGE_W'(g)),
      .in_valid  (chain_valid[g]),
      .in_item   (chain_item[g]),
      .out_valid (chain_valid[g+1]),
      .out_item  (chain_item[g+1])
    );
  end

  tcpc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (chain_valid[CORDIC_STAGES]),
    .in_item   (chain_item[CORDIC_STAGES]),
    .out_valid (m_tvalid),
    .out_data  (m_tdata)
  );

  `TCPC_ASSERT_IMPL(a_stall_blocks_input, m_tvalid && !m_tready, !s_tready, "input taken while output stalled")
  `TCPC_ASSERT_IMPL(a_idle_no_polar, m_tvalid && m_tdata[31], m_tdata[62:32] == '0, "idle report carries polar values")
  `TCPC_ASSERT_IMPL(a_angle_range, m_tvalid, ($signed(m_tdata[47:32]) <= 16'sd23040) && ($signed(m_tdata[47:32]) >= -16'sd23039), "angle out of range")
  `TCPC_ASSERT_NEXT(a_last_cell_moves, chain_valid[CORDIC_STAGES] && en, m_tvalid, "result lost at output register")

endmodule

[tb/sv/tb_touch_clamp_polar_convert.sv]
// Self-checking testbench for touch_clamp_polar_convert: clamp, idle passthrough and CORDIC polar.
// Needs tcpc_pkg and the block's RTL; a local model predicts the untyped results from the live settings.
`timescale 1ns / 1ps

module tb_touch_clamp_polar_convert;
  import tcpc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 62;

  // Arctangent steps in 1/32768 degree for each micro-rotation.
  localparam longint ATAN_STEP [24] = '{
    1474560, 870484, 459940, 233473, 117189, 58652, 29333, 14667,
    7334, 3667, 1833, 917, 458, 229, 115, 57,
    29, 14, 7, 4, 2, 1, 0, 0
  };

  localparam logic [IDX_W-1:0] REG_ORDER [6] = '{
    REG_X_LOW, REG_X_HIGH, REG_Y_LOW, REG_Y_HIGH, REG_X_CTR, REG_Y_CTR
  };

  // Packed so that the last field sits in the lowest bits of tdata.
  typedef struct packed {
    logic [BTN_W-1:0] button_bits;
    logic [Z_W-1:0]   z_level;
    logic [XY_W-1:0]  y_position;
    logic [XY_W-1:0]  x_position;
  } touch_report_t;

  typedef struct packed {
    logic [RAD_W-1:0]        radius_fixed;
    logic signed [ANG_W-1:0] angle_deg;
    logic                    idle_flag;
    logic [BTN_W-1:0]        buttons_out;
    logic [Z_W-1:0]          z_out;
    logic [XY_W-1:0]         y_clamped;
    logic [XY_W-1:0]         x_clamped;
  } polar_result_t;

  typedef enum logic [1:0] {ROW_REPORT, ROW_TYPED, ROW_CONFIG} row_kind_t;

  typedef struct packed {
    row_kind_t     kind;
    cfg_t          settings;
    touch_report_t report;
    polar_result_t want;
  } stim_row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic             cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [XY_W-1:0]  cfg_data = '0;

  cfg_t          live_cfg;
  polar_result_t pending_polar [$];
  polar_result_t got_res, want_res;
  stim_row_t     stim_rows [$];
  bit            calm = 1'b0;
  int            hold_cycles = 0;
  int            cycle_count = 0;
  int            failures = 0;
  int            reports_sent = 0;
  int            results_seen = 0;
  int            idle_seen = 0;
  int            saturated_seen = 0;
  int            settings_applied = 0;

  touch_clamp_polar_convert u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic polar_result_t polar_of(touch_report_t rep);
    polar_result_t res;
    logic [XY_W-1:0] xv, yv;
    longint cx, cy, acc, sx, sy, ang, rad;
    int i;
    xv = rep.x_position;
    yv = rep.y_position;
    ang = 0;
    rad = 0;
    acc = 0;
    if (rep.z_level != 0) begin
      // The high limit is tested first; with crossed limits it wins for inputs above it.
      if (xv > live_cfg.x_high_limit) xv = live_cfg.x_high_limit;
      else if (xv < live_cfg.x_low_limit) xv = live_cfg.x_low_limit;
      if (yv > live_cfg.y_high_limit) yv = live_cfg.y_high_limit;
      else if (yv < live_cfg.y_low_limit) yv = live_cfg.y_low_limit;
      cx = (longint'(xv) - longint'(live_cfg.x_center)) * 256;
      cy = (longint'(yv) - longint'(live_cfg.y_center)) * 256;
      // Vectors in the left half plane are turned by a half turn first.
      if (cx < 0) begin
        acc = (cy >= 0) ? longint'(HALF_TURN) * 256 : -longint'(HALF_TURN) * 256;
        cx = -cx;
        cy = -cy;
      end
      if (cx != 0 || cy != 0) begin
        for (i = 0; i < CORDIC_STAGES && i < 24; i++) begin
          sx = cx >>> i;
          sy = cy >>> i;
          if (cy >= 0) begin
            cx = cx + sy;
            cy = cy - sx;
            acc = acc + ATAN_STEP[i];
          end else begin
            cx = cx - sy;
            cy = cy + sx;
            acc = acc - ATAN_STEP[i];
          end
        end
        ang = (acc + 128) >>> 8;
        if (ang > HALF_TURN) ang = HALF_TURN;
        if (ang < -(HALF_TURN - 1)) ang = -(HALF_TURN - 1);
        if (cx < 0) cx = 0;
        rad = (cx * GAIN_Q16 + (longint'(1) << 19)) >>> 20;
        if (rad > 32767) rad = 32767;
      end
    end
    res.x_clamped    = xv;
    res.y_clamped    = yv;
    res.z_out        = rep.z_level;
    res.buttons_out  = rep.button_bits;
    res.idle_flag    = (rep.z_level == 0);
    res.angle_deg    = ang[ANG_W-1:0];
    res.radius_fixed = rad[RAD_W-1:0];
    return res;
  endfunction

  function automatic int pick_pause();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [XY_W-1:0] pick_axis(logic [XY_W-1:0] lo, logic [XY_W-1:0] hi,
                                                logic [XY_W-1:0] ctr);
    int base;
    if ($urandom_range(0, 99) < 70) return XY_W'($urandom);
    case ($urandom_range(0, 4))
      0: base = 0;
      1: base = 2047;
      2: base = lo;
      3: base = hi;
      default: base = ctr;
    endcase
    base = base + int'($urandom_range(0, 4)) - 2;
    if (base < 0) base = 0;
    if (base > 2047) base = 2047;
    return XY_W'(base);
  endfunction

  function automatic stim_row_t report_row(int x, int y, int z, int b);
    stim_row_t row;
    row = '0;
    row.kind = ROW_REPORT;
    row.report.x_position  = XY_W'(x);
    row.report.y_position  = XY_W'(y);
    row.report.z_level     = Z_W'(z);
    row.report.button_bits = BTN_W'(b);
    return row;
  endfunction

  // Rows whose outcome is obvious: idle reports and zero offsets give no angle and no radius.
  function automatic stim_row_t typed_row(int x, int y, int z, int b, int xc, int yc);
    stim_row_t row;
    row = report_row(x, y, z, b);
    row.kind = ROW_TYPED;
    row.want.x_clamped   = XY_W'(xc);
    row.want.y_clamped   = XY_W'(yc);
    row.want.z_out       = Z_W'(z);
    row.want.buttons_out = BTN_W'(b);
    row.want.idle_flag   = (z == 0);
    return row;
  endfunction

  function automatic cfg_t make_cfg(int xl, int xh, int yl, int yh, int xc, int yc);
    cfg_t c;
    c.x_low_limit  = XY_W'(xl);
    c.x_high_limit = XY_W'(xh);
    c.y_low_limit  = XY_W'(yl);
    c.y_high_limit = XY_W'(yh);
    c.x_center     = XY_W'(xc);
    c.y_center     = XY_W'(yc);
    return c;
  endfunction

  function automatic stim_row_t config_row(cfg_t c);
    stim_row_t row;
    row = '0;
    row.kind = ROW_CONFIG;
    row.settings = c;
    return row;
  endfunction

  task automatic send_report(touch_report_t rep, bit typed, polar_result_t want);
    int gap;
    gap = (calm || $urandom_range(0, 99) < 55) ? 0 : pick_pause();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, rep};
    do @(posedge clk); while (!s_tready);
    pending_polar.push_back(typed ? want : polar_of(rep));
    reports_sent++;
  endtask

  // Every report yields a result, so an empty queue means the pipeline is empty.
  task automatic apply_settings(cfg_t c);
    logic [XY_W-1:0] vals [6];
    int i;
    s_tvalid <= 1'b0;
    while (pending_polar.size() != 0) @(posedge clk);
    vals = '{c.x_low_limit, c.x_high_limit, c.y_low_limit, c.y_high_limit,
             c.x_center, c.y_center};
    for (i = 0; i < 6; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= REG_ORDER[i];
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    live_cfg = c;
    settings_applied++;
  endtask

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      m_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 99) < 25) begin
      hold_cycles = pick_pause() - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_res = polar_result_t'(m_tdata[62:0]);
      if (pending_polar.size() == 0) begin
        $error("result transfer with no report pending");
        failures++;
      end else begin
        want_res = pending_polar.pop_front();
        results_seen++;
        if (got_res.idle_flag) idle_seen++;
        if (got_res.radius_fixed == 15'h7FFF) saturated_seen++;
        if (got_res.x_clamped !== want_res.x_clamped) begin
          $error("x_clamped: expected %0d, actual %0d", want_res.x_clamped, got_res.x_clamped);
          failures++;
        end
        if (got_res.y_clamped !== want_res.y_clamped) begin
          $error("y_clamped: expected %0d, actual %0d", want_res.y_clamped, got_res.y_clamped);
          failures++;
        end
        if (got_res.z_out !== want_res.z_out) begin
          $error("z_out: expected %0d, actual %0d", want_res.z_out, got_res.z_out);
          failures++;
        end
        if (got_res.buttons_out !== want_res.buttons_out) begin
          $error("buttons_out: expected %0d, actual %0d", want_res.buttons_out,
                 got_res.buttons_out);
          failures++;
        end
        if (got_res.idle_flag !== want_res.idle_flag) begin
          $error("idle_flag: expected %0d, actual %0d", want_res.idle_flag, got_res.idle_flag);
          failures++;
        end
        if (got_res.angle_deg !== want_res.angle_deg) begin
          $error("angle_deg: expected %0d, actual %0d", want_res.angle_deg, got_res.angle_deg);
          failures++;
        end
        if (got_res.radius_fixed !== want_res.radius_fixed) begin
          $error("radius_fixed: expected %0d, actual %0d", want_res.radius_fixed,
                 got_res.radius_fixed);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.", cycle_count,
               pending_polar.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    touch_report_t rep;
    cfg_t          c;
    int            ph, n, r;

    live_cfg = make_cfg(128, 1920, 64, 1472, 960, 736);

    // Reset defaults: idle passthrough, zero offset, clamping on each edge, half-turn edges.
    stim_rows.push_back(typed_row(2047, 2047, 0, 7, 2047, 2047));
    stim_rows.push_back(typed_row(0, 0, 0, 0, 0, 0));
    stim_rows.push_back(typed_row(960, 736, 1, 5, 960, 736));
    stim_rows.push_back(report_row(0, 736, 63, 1));
    stim_rows.push_back(report_row(2047, 736, 10, 2));
    stim_rows.push_back(report_row(960, 0, 33, 4));
    stim_rows.push_back(report_row(960, 2047, 1, 3));
    stim_rows.push_back(report_row(0, 0, 7, 6));
    stim_rows.push_back(report_row(2047, 2047, 62, 0));
    stim_rows.push_back(report_row(0, 2047, 21, 7));
    stim_rows.push_back(report_row(2047, 0, 42, 1));
    stim_rows.push_back(report_row(0, 735, 20, 2));
    stim_rows.push_back(report_row(960, 1000, 5, 0));
    // Full range with the origin in the corner: the far corner saturates the radius.
    stim_rows.push_back(config_row(make_cfg(0, 2047, 0, 2047, 0, 0)));
    stim_rows.push_back(report_row(2047, 2047, 1, 5));
    stim_rows.push_back(typed_row(0, 0, 1, 6, 0, 0));
    stim_rows.push_back(report_row(2047, 0, 63, 3));
    // Crossed limits.
    stim_rows.push_back(config_row(make_cfg(1500, 500, 1200, 300, 1000, 800)));
    stim_rows.push_back(report_row(1000, 1000, 9, 7));
    stim_rows.push_back(report_row(200, 100, 18, 4));
    stim_rows.push_back(report_row(2047, 2047, 27, 2));
    stim_rows.push_back(typed_row(1000, 100, 0, 1, 1000, 100));
    // Everything at the top: any touch lands on the center.
    stim_rows.push_back(config_row(make_cfg(2047, 2047, 2047, 2047, 2047, 2047)));
    stim_rows.push_back(typed_row(5, 1800, 63, 7, 2047, 2047));

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_CONFIG) apply_settings(stim_rows[i].settings);
      else send_report(stim_rows[i].report, stim_rows[i].kind == ROW_TYPED,
                       stim_rows[i].want);
    end

    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: c = make_cfg(128, 1920, 64, 1472, 960, 736);
        1: c = make_cfg(0, 0, 0, 0, 0, 0);
        2: c = make_cfg(2047, 2047, 2047, 2047, 2047, 2047);
        3: c = make_cfg(0, 2047, 0, 2047, 1024, 1024);
        4: c = make_cfg(0, 2047, 0, 2047, 0, 0);
        5: c = make_cfg(0, 2047, 0, 2047, 2047, 2047);
        default: c = make_cfg($urandom_range(0, 2047), $urandom_range(0, 2047),
                              $urandom_range(0, 2047), $urandom_range(0, 2047),
                              $urandom_range(0, 2047), $urandom_range(0, 2047));
      endcase
      apply_settings(c);
      calm = (ph == 3);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        rep.x_position = pick_axis(live_cfg.x_low_limit, live_cfg.x_high_limit,
                                   live_cfg.x_center);
        rep.y_position = pick_axis(live_cfg.y_low_limit, live_cfg.y_high_limit,
                                   live_cfg.y_center);
        r = $urandom_range(0, 99);
        if (r < 15) rep.z_level = '0;
        else if (r < 25) rep.z_level = '1;
        else rep.z_level = Z_W'($urandom_range(1, 63));
        rep.button_bits = BTN_W'($urandom);
        send_report(rep, 1'b0, '0);
      end
    end
    calm = 1'b0;

    s_tvalid <= 1'b0;
    while (pending_polar.size() != 0) @(posedge clk);
    repeat (CORDIC_STAGES + 4) @(posedge clk);

    $display("Sent %0d reports under %0d register settings; %0d results checked.",
             reports_sent, settings_applied, results_seen);
    $display("Of those, %0d were idle and %0d had a saturated radius.", idle_seen,
             saturated_seen);
    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
